// ----- hdl/tsc_pkg.sv -----
`timescale 1ns / 1ps

package tsc_pkg;

   localparam int LRU_SLOTS   = 4;
   localparam int FIFO_SLOTS  = 4;
   localparam int AGE_BITS    = 16;
   localparam int TOTAL_SLOTS = LRU_SLOTS + FIFO_SLOTS;

   localparam int IDX_W  = (TOTAL_SLOTS > 1) ? $clog2(TOTAL_SLOTS) : 1;
   localparam int LRU_W  = (LRU_SLOTS > 1) ? $clog2(LRU_SLOTS) : 1;
   localparam int FIFO_W = (FIFO_SLOTS > 1) ? $clog2(FIFO_SLOTS) : 1;

   localparam int TIME_W    = 64;
   localparam int HANDLE_W  = 32;
   localparam int COUNT_W   = 32;
   localparam int SLOT_W    = 3;
   localparam int PROMO_W   = 2;
   localparam int OUTCOME_W = 2;

   typedef logic [AGE_BITS-1:0] age_type;

   localparam age_type AGE_MAX = '1;

   typedef struct packed {
      logic [TIME_W-1:0]   start_time;
      logic [TIME_W-1:0]   end_time;
      logic [HANDLE_W-1:0] handle;
   } slot_rec_type;

   typedef enum logic [OUTCOME_W-1:0] {
      OUT_LRU_HIT  = 2'd0,
      OUT_FIFO_HIT = 2'd1,
      OUT_MISS     = 2'd2,
      OUT_FILL     = 2'd3
   } outcome_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_LAST,
      ST_FINISH,
      ST_RESP
   } state_type;

endpackage

// ----- hdl/two_queue_slice_cache.sv -----
`timescale 1ns / 1ps

// Two-queue slice cache. Slots 0..3 form the LRU queue and slots 4..7 the FIFO queue;
// slot records live in a single-port-read RAM and LRU ages in a second RAM. A lookup
// scans every slot once through the record RAM read port, one slot per cycle, while it
// ages the LRU slots and tracks the oldest one, then commits the hit, promotion or miss.
// A lookup result loads into the output register from ST_RESP once the scan has drained
// through ST_LAST and ST_FINISH, and a fill result loads from ST_RESP, which a fill enters
// straight from ST_IDLE; the next request is taken the cycle after the result loads. A result
// may wait on rsp_stall while the next request is in progress; that request then holds in
// its final state until the output register frees. Requests with end <= start or never
// filled slots never hit.
module two_queue_slice_cache (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_mode,
   input  logic [tsc_pkg::TIME_W-1:0]   req_timestamp,
   input  logic [2:0]                   req_fill_slot,
   input  logic [tsc_pkg::TIME_W-1:0]   req_fill_start,
   input  logic [tsc_pkg::TIME_W-1:0]   req_fill_end,
   input  logic [tsc_pkg::HANDLE_W-1:0] req_fill_handle,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [1:0]                   rsp_outcome,
   output logic [2:0]                   rsp_slot,
   output logic [tsc_pkg::HANDLE_W-1:0] rsp_handle,
   output logic [1:0]                   rsp_promoted_slot,
   output logic [tsc_pkg::COUNT_W-1:0]  rsp_hit_count,
   output logic [tsc_pkg::COUNT_W-1:0]  rsp_miss_count
);

   localparam logic [tsc_pkg::IDX_W-1:0]  LRU_IDX  = tsc_pkg::IDX_W'(tsc_pkg::LRU_SLOTS);
   localparam logic [tsc_pkg::IDX_W-1:0]  LAST_IDX = tsc_pkg::IDX_W'(tsc_pkg::TOTAL_SLOTS - 1);
   localparam logic [tsc_pkg::FIFO_W-1:0] LAST_PTR = tsc_pkg::FIFO_W'(tsc_pkg::FIFO_SLOTS - 1);
   localparam int REC_W = $bits(tsc_pkg::slot_rec_type);

   tsc_pkg::state_type state_ff, state_in;

   logic                          issue;
   logic                          accept;
   logic                          rsp_load;

   logic [tsc_pkg::IDX_W-1:0]     idx_ff;
   logic                          rd_valid_ff;
   logic [tsc_pkg::IDX_W-1:0]     rd_idx_ff;
   logic [tsc_pkg::TIME_W-1:0]    ts_ff;

   logic                          found_ff;
   logic [tsc_pkg::IDX_W-1:0]     hit_idx_ff;
   tsc_pkg::slot_rec_type         hit_rec_ff;
   tsc_pkg::age_type              max_ff;
   logic [tsc_pkg::LRU_W-1:0]     oldest_ff;

   logic [tsc_pkg::TOTAL_SLOTS-1:0] slot_valid_ff;
   logic [tsc_pkg::LRU_SLOTS-1:0]   age_valid_ff;
   logic [tsc_pkg::FIFO_W-1:0]      ptr_ff;
   logic [tsc_pkg::COUNT_W-1:0]     hits_ff;
   logic [tsc_pkg::COUNT_W-1:0]     misses_ff;

   tsc_pkg::outcome_type          pend_outcome_ff;
   logic [tsc_pkg::SLOT_W-1:0]    pend_slot_ff;
   logic [tsc_pkg::HANDLE_W-1:0]  pend_handle_ff;
   logic [tsc_pkg::PROMO_W-1:0]   pend_promoted_ff;

   logic                          rsp_valid_ff;
   logic [1:0]                    rsp_outcome_ff;
   logic [2:0]                    rsp_slot_ff;
   logic [tsc_pkg::HANDLE_W-1:0]  rsp_handle_ff;
   logic [1:0]                    rsp_promoted_ff;
   logic [tsc_pkg::COUNT_W-1:0]   rsp_hits_ff;
   logic [tsc_pkg::COUNT_W-1:0]   rsp_misses_ff;

   logic                          rec_wr_en;
   logic [tsc_pkg::IDX_W-1:0]     rec_wr_addr;
   tsc_pkg::slot_rec_type         rec_wr_data;
   tsc_pkg::slot_rec_type         rec_rd_data;

   logic                          age_wr_en;
   logic [tsc_pkg::LRU_W-1:0]     age_wr_addr;
   tsc_pkg::age_type              age_wr_data;
   tsc_pkg::age_type              age_rd_data;
   logic                          age_rd_en;

   logic                          rd_is_lru;
   logic [tsc_pkg::LRU_W-1:0]     rd_age_addr;
   tsc_pkg::age_type              age_cur;
   tsc_pkg::age_type              age_inc;
   logic                          rd_hit;
   logic                          fill_in_range;
   logic                          fin_lru_hit;
   logic                          fin_fifo_hit;

   tsc_ram #(
      .DATA_W (REC_W),
      .DEPTH  (tsc_pkg::TOTAL_SLOTS)
   ) u_rec_ram (
      .clock   (clock),
      .wr_en   (rec_wr_en),
      .wr_addr (rec_wr_addr),
      .wr_data (rec_wr_data),
      .rd_en   (issue),
      .rd_addr (idx_ff),
      .rd_data (rec_rd_data)
   );

   tsc_ram #(
      .DATA_W (tsc_pkg::AGE_BITS),
      .DEPTH  (tsc_pkg::LRU_SLOTS)
   ) u_age_ram (
      .clock   (clock),
      .wr_en   (age_wr_en),
      .wr_addr (age_wr_addr),
      .wr_data (age_wr_data),
      .rd_en   (age_rd_en),
      .rd_addr (idx_ff[tsc_pkg::LRU_W-1:0]),
      .rd_data (age_rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tsc_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = req_mode ? tsc_pkg::ST_RESP : tsc_pkg::ST_SCAN;
            end
         end
         tsc_pkg::ST_SCAN: begin
            if (idx_ff == LAST_IDX) begin
               state_in = tsc_pkg::ST_LAST;
            end
         end
         tsc_pkg::ST_LAST:   state_in = tsc_pkg::ST_FINISH;
         tsc_pkg::ST_FINISH: state_in = tsc_pkg::ST_RESP;
         tsc_pkg::ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = tsc_pkg::ST_IDLE;
            end
         end
         default: state_in = tsc_pkg::ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_stall = 1'b1;
      issue     = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         tsc_pkg::ST_IDLE:   req_stall = 1'b0;
         tsc_pkg::ST_SCAN:   issue     = 1'b1;
         tsc_pkg::ST_LAST:   ;
         tsc_pkg::ST_FINISH: ;
         tsc_pkg::ST_RESP:   rsp_load  = !rsp_valid_ff || !rsp_stall;
         default:            req_stall = 1'b1;
      endcase
   end

   assign accept    = req_valid && !req_stall;
   assign age_rd_en = issue && (idx_ff < LRU_IDX);

   // scan data stage
   always_comb begin
      rd_is_lru   = rd_idx_ff < LRU_IDX;
      rd_age_addr = rd_idx_ff[tsc_pkg::LRU_W-1:0];
      age_cur     = age_valid_ff[rd_age_addr] ? age_rd_data : '0;
      age_inc     = (age_cur == tsc_pkg::AGE_MAX) ? age_cur : age_cur + 1'b1;
      rd_hit      = slot_valid_ff[rd_idx_ff]
                    && (rec_rd_data.start_time <= ts_ff)
                    && (ts_ff < rec_rd_data.end_time);
   end

   assign fill_in_range = {1'b0, req_fill_slot} < 4'(tsc_pkg::TOTAL_SLOTS);
   assign fin_lru_hit   = (state_ff == tsc_pkg::ST_FINISH) && found_ff && (hit_idx_ff < LRU_IDX);
   assign fin_fifo_hit  = (state_ff == tsc_pkg::ST_FINISH) && found_ff && (hit_idx_ff >= LRU_IDX);

   // RAM write ports
   always_comb begin
      rec_wr_en   = 1'b0;
      rec_wr_addr = tsc_pkg::IDX_W'(req_fill_slot);
      rec_wr_data = '{start_time: req_fill_start, end_time: req_fill_end,
                      handle: req_fill_handle};
      if (accept && req_mode) begin
         rec_wr_en = fill_in_range;
      end else if (fin_fifo_hit) begin
         rec_wr_en   = 1'b1;
         rec_wr_addr = tsc_pkg::IDX_W'(oldest_ff);
         rec_wr_data = hit_rec_ff;
      end
   end

   always_comb begin
      age_wr_en   = 1'b0;
      age_wr_addr = rd_age_addr;
      age_wr_data = age_inc;
      if (rd_valid_ff && rd_is_lru) begin
         age_wr_en = 1'b1;
      end else if (fin_lru_hit) begin
         age_wr_en   = 1'b1;
         age_wr_addr = hit_idx_ff[tsc_pkg::LRU_W-1:0];
         age_wr_data = '0;
      end else if (fin_fifo_hit) begin
         age_wr_en   = 1'b1;
         age_wr_addr = oldest_ff;
         age_wr_data = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= tsc_pkg::ST_IDLE;
         rd_valid_ff   <= 1'b0;
         slot_valid_ff <= '0;
         age_valid_ff  <= '0;
         ptr_ff        <= '0;
         hits_ff       <= '0;
         misses_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         rd_valid_ff <= issue;
         if (accept && req_mode && fill_in_range) begin
            slot_valid_ff[tsc_pkg::IDX_W'(req_fill_slot)] <= 1'b1;
         end
         if (fin_fifo_hit) begin
            slot_valid_ff[tsc_pkg::IDX_W'(oldest_ff)] <= 1'b1;
         end
         if (age_wr_en) begin
            age_valid_ff[age_wr_addr] <= 1'b1;
         end
         if (state_ff == tsc_pkg::ST_FINISH) begin
            if (found_ff) begin
               hits_ff <= hits_ff + 1'b1;
            end else begin
               misses_ff <= misses_ff + 1'b1;
               ptr_ff    <= (ptr_ff == LAST_PTR) ? '0 : ptr_ff + 1'b1;
            end
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (accept) begin
         ts_ff     <= req_timestamp;
         idx_ff    <= '0;
         found_ff  <= 1'b0;
         max_ff    <= '0;
         oldest_ff <= '0;
      end else if (issue) begin
         idx_ff <= idx_ff + 1'b1;
      end
      rd_idx_ff <= idx_ff;
      if (rd_valid_ff) begin
         if (rd_hit && !found_ff) begin
            found_ff   <= 1'b1;
            hit_idx_ff <= rd_idx_ff;
            hit_rec_ff <= rec_rd_data;
         end
         if (rd_is_lru && (age_inc > max_ff)) begin
            max_ff    <= age_inc;
            oldest_ff <= rd_age_addr;
         end
      end
      if (accept && req_mode) begin
         pend_outcome_ff  <= tsc_pkg::OUT_FILL;
         pend_slot_ff     <= req_fill_slot;
         pend_handle_ff   <= req_fill_handle;
         pend_promoted_ff <= '0;
      end else if (state_ff == tsc_pkg::ST_FINISH) begin
         if (fin_lru_hit) begin
            pend_outcome_ff  <= tsc_pkg::OUT_LRU_HIT;
            pend_slot_ff     <= tsc_pkg::SLOT_W'(hit_idx_ff);
            pend_handle_ff   <= hit_rec_ff.handle;
            pend_promoted_ff <= '0;
         end else if (fin_fifo_hit) begin
            pend_outcome_ff  <= tsc_pkg::OUT_FIFO_HIT;
            pend_slot_ff     <= tsc_pkg::SLOT_W'(hit_idx_ff);
            pend_handle_ff   <= hit_rec_ff.handle;
            pend_promoted_ff <= tsc_pkg::PROMO_W'(oldest_ff);
         end else begin
            pend_outcome_ff  <= tsc_pkg::OUT_MISS;
            pend_slot_ff     <= tsc_pkg::SLOT_W'(LRU_IDX + tsc_pkg::IDX_W'(ptr_ff));
            pend_handle_ff   <= '0;
            pend_promoted_ff <= '0;
         end
      end
      if (rsp_load) begin
         rsp_outcome_ff  <= pend_outcome_ff;
         rsp_slot_ff     <= pend_slot_ff;
         rsp_handle_ff   <= pend_handle_ff;
         rsp_promoted_ff <= pend_promoted_ff;
         rsp_hits_ff     <= hits_ff;
         rsp_misses_ff   <= misses_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_outcome       = rsp_outcome_ff;
   assign rsp_slot          = rsp_slot_ff;
   assign rsp_handle        = rsp_handle_ff;
   assign rsp_promoted_slot = rsp_promoted_ff;
   assign rsp_hit_count     = rsp_hits_ff;
   assign rsp_miss_count    = rsp_misses_ff;

   a_scan_drained: assert property (@(posedge clock) disable iff (reset)
      state_ff == tsc_pkg::ST_FINISH |-> !rd_valid_ff)
      else $error("scan read still in flight at commit");

   a_lookup_starts: assert property (@(posedge clock) disable iff (reset)
      accept && !req_mode |=> state_ff == tsc_pkg::ST_SCAN && idx_ff == '0)
      else $error("lookup did not start scan at first slot");

   a_miss_counted: assert property (@(posedge clock) disable iff (reset)
      state_ff == tsc_pkg::ST_FINISH && !found_ff |=> misses_ff == $past(misses_ff) + 1'b1)
      else $error("miss not counted");

endmodule

// ----- hdl/tsc_ram.sv -----
`timescale 1ns / 1ps

module tsc_ram #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 8,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
